[rtl/u8250_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and functions for the 8250-style UART register model.
// Used by the top level and by the testbench; depends on nothing.
package u8250_pkg;

  // Receive ring geometry.
  localparam int RING_DEPTH = 256;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(RING_DEPTH - 1);

  // Item kinds on the input channel.
  typedef enum logic [1:0] {
    FUNC_READ     = 2'd0,
    FUNC_WRITE    = 2'd1,
    FUNC_RX_BYTE  = 2'd2,
    FUNC_RX_DELAY = 2'd3
  } func_t;

  // Register offsets within the port.
  typedef enum logic [2:0] {
    ADDR_DATA = 3'd0,
    ADDR_IER  = 3'd1,
    ADDR_IIR  = 3'd2,
    ADDR_LCR  = 3'd3,
    ADDR_MCR  = 3'd4,
    ADDR_LSR  = 3'd5,
    ADDR_MSR  = 3'd6,
    ADDR_SCR  = 3'd7
  } reg_addr_t;

  // Interrupt identification codes.
  localparam logic [3:0] IIR_NONE = 4'd1;
  localparam logic [3:0] IIR_LSR  = 4'd6;
  localparam logic [3:0] IIR_RX   = 4'd4;
  localparam logic [3:0] IIR_TX   = 4'd2;
  localparam logic [3:0] IIR_MSR  = 4'd0;

  // Bit positions in the pending-interrupt vector.
  localparam int PEND_LSR = 0;
  localparam int PEND_RX  = 1;
  localparam int PEND_TX  = 2;
  localparam int PEND_MSR = 3;

  // Interrupt ranking: line status, receive, transmit, modem status.
  function automatic logic [3:0] int_prio(input logic [3:0] ier, input logic [3:0] pend);
    logic [3:0] id;
    id = IIR_NONE;
    if (ier[2] && pend[PEND_LSR]) begin
      id = IIR_LSR;
    end else if (ier[0] && pend[PEND_RX]) begin
      id = IIR_RX;
    end else if (ier[1] && pend[PEND_TX]) begin
      id = IIR_TX;
    end else if (ier[3] && pend[PEND_MSR]) begin
      id = IIR_MSR;
    end
    return id;
  endfunction

  // Ring pointer advance with wrap at the ring depth.
  function automatic logic [RING_AW-1:0] ring_inc(input logic [RING_AW-1:0] p);
    return (p == RING_LAST) ? '0 : RING_AW'(p + 1'b1);
  endfunction

endpackage

[rtl/u8250_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with a registered read port.
// Self-contained; holds the receive ring of the UART register model.
module u8250_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next enabled read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/uart_8250_register_model.sv]
`timescale 1ns / 1ps
// Top level of the 8250-style UART register model: register file, interrupt logic
// and receive ring control. Depends on u8250_pkg and u8250_ram.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item per transfer: a bus read,
//   a bus write, a byte received from the attached device, or a receive-delay
//   expiry (func, bus_address, data_byte).
//   Output channel (out_valid / out_stall) returns one result per item: read data,
//   IRQ level, RTS-rise event and a request to arm the receive delay timer.
//   Configuration channel (cfg_valid / cfg_ready, data irq_always_enabled) writes
//   the single mode bit; it is always ready and should be used while idle.
// Timing:
//   A result appears in the output register on the cycle after its transfer in.
//   One item is taken every cycle; the ring memory read issued at acceptance
//   lands on the same edge that loads the output register.
//   While a result waits under out_stall, in_stall is raised and the item held.
// Reset:
//   Synchronous reset clears the register file, mode bit, out_valid and ring pointers,
//   so the ring is empty at once; the result payload and ring memory are not cleared.
module uart_8250_register_model
  import u8250_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // Input item channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] func,
  input  logic [2:0] bus_address,
  input  logic [7:0] data_byte,
  // Result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       irq_level,
  output logic       rts_request,
  output logic       arm_rx_delay,
  // Configuration channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       irq_always_enabled
);

  // Architectural registers.
  logic         irq_always;
  logic [3:0]   int_enable, int_enable_next;
  logic [7:0]   line_control, line_control_next;
  logic [7:0]   modem_control, modem_control_next;
  logic [7:0]   line_status, line_status_next;
  logic [7:0]   modem_status, modem_status_next;
  logic         fifo_enable, fifo_enable_next;
  logic [7:0]   scratch_reg, scratch_reg_next;
  logic [7:0]   divisor_low, divisor_low_next;
  logic [7:0]   divisor_high, divisor_high_next;
  logic [3:0]   pending_ints, pending_ints_next;
  logic [RING_AW-1:0] ring_read_ptr, ring_read_ptr_next;
  logic [RING_AW-1:0] ring_write_ptr, ring_write_ptr_next;
  logic [7:0]   last_rx_data;
  logic         pop_pending;

  // Result register.
  logic [7:0]   rd_hold, rd_hold_next;
  logic         use_ring, use_ring_next;
  logic         irq_next, rts_next, arm_next;

  // Ring memory interface.
  logic         ram_we, ram_re;
  logic [7:0]   ram_rdata;

  // Working values.
  logic         accept;
  logic         ring_has_data;
  logic         push;
  logic [3:0]   int_ident;
  logic [7:0]   last_eff;
  logic [7:0]   msr_loop;

  assign accept        = in_valid && !in_stall;
  assign in_stall      = out_valid && out_stall;
  assign cfg_ready     = 1'b1;
  assign ring_has_data = (ring_read_ptr != ring_write_ptr);
  assign int_ident     = int_prio(int_enable, pending_ints);

  // The last dequeued byte still sits in the memory read register after a pop.
  assign last_eff = pop_pending ? ram_rdata : last_rx_data;

  // Item processing: read-modify-write of the register file for one item.
  always_comb begin
    int_enable_next     = int_enable;
    line_control_next   = line_control;
    modem_control_next  = modem_control;
    line_status_next    = line_status;
    modem_status_next   = modem_status;
    fifo_enable_next    = fifo_enable;
    scratch_reg_next    = scratch_reg;
    divisor_low_next    = divisor_low;
    divisor_high_next   = divisor_high;
    pending_ints_next   = pending_ints;
    ring_read_ptr_next  = ring_read_ptr;
    ring_write_ptr_next = ring_write_ptr;
    rd_hold_next        = 8'd0;
    use_ring_next       = 1'b0;
    rts_next            = 1'b0;
    arm_next            = 1'b0;
    ram_re              = 1'b0;
    ram_we              = 1'b0;
    push                = 1'b0;
    msr_loop            = 8'd0;

    unique case (func_t'(func))
      FUNC_READ: begin
        unique case (reg_addr_t'(bus_address))
          ADDR_DATA: begin
            if (line_control[7]) begin
              rd_hold_next = divisor_low;
            end else begin
              line_status_next[0]         = 1'b0;
              pending_ints_next[PEND_RX]  = 1'b0;
              if (ring_has_data) begin
                ram_re             = 1'b1;
                use_ring_next      = 1'b1;
                ring_read_ptr_next = ring_inc(ring_read_ptr);
                arm_next           = (ring_read_ptr_next != ring_write_ptr);
              end else begin
                rd_hold_next = last_eff;
              end
            end
          end
          ADDR_IER: begin
            rd_hold_next = line_control[7] ? divisor_high : {4'd0, int_enable};
          end
          ADDR_IIR: begin
            rd_hold_next = {4'd0, int_ident};
            if (int_ident[3:1] == IIR_TX[3:1]) begin
              pending_ints_next[PEND_TX] = 1'b0;
            end
            if (fifo_enable) begin
              rd_hold_next[7:6] = 2'b11;
            end
          end
          ADDR_LCR: begin
            rd_hold_next = line_control;
          end
          ADDR_MCR: begin
            rd_hold_next = modem_control;
          end
          ADDR_LSR: begin
            if (line_status[5]) begin
              line_status_next[6] = 1'b1;
            end
            line_status_next[5]         = 1'b1;
            rd_hold_next                = line_status_next;
            line_status_next[4:1]       = 4'd0;
            pending_ints_next[PEND_LSR] = 1'b0;
          end
          ADDR_MSR: begin
            rd_hold_next                = modem_status;
            modem_status_next[3:0]      = 4'd0;
            pending_ints_next[PEND_MSR] = 1'b0;
          end
          ADDR_SCR: begin
            rd_hold_next = scratch_reg;
          end
          default: begin
            rd_hold_next = 8'd0;
          end
        endcase
      end

      FUNC_WRITE: begin
        unique case (reg_addr_t'(bus_address))
          ADDR_DATA: begin
            if (line_control[7]) begin
              divisor_low_next = data_byte;
            end else begin
              line_status_next[5]        = 1'b1;
              pending_ints_next[PEND_TX] = 1'b1;
              push                       = modem_control[4];
            end
          end
          ADDR_IER: begin
            if (line_control[7]) begin
              divisor_high_next = data_byte;
            end else begin
              int_enable_next = data_byte[3:0];
            end
          end
          ADDR_IIR: begin
            fifo_enable_next = data_byte[0];
          end
          ADDR_LCR: begin
            line_control_next = data_byte;
          end
          ADDR_MCR: begin
            rts_next           = data_byte[1] && !modem_control[1];
            modem_control_next = data_byte;
            // Loopback: outputs drive the modem status inputs, with delta bits.
            if (data_byte[4]) begin
              msr_loop[7:6] = data_byte[3:2];
              msr_loop[4]   = data_byte[1];
              msr_loop[5]   = data_byte[0];
              msr_loop[0]   = modem_status[4] ^ msr_loop[4];
              msr_loop[1]   = modem_status[5] ^ msr_loop[5];
              msr_loop[3]   = modem_status[7] ^ msr_loop[7];
              msr_loop[2]   = modem_status[6] && !msr_loop[6];
              modem_status_next = msr_loop;
            end
          end
          ADDR_LSR: begin
            line_status_next = data_byte;
            if (data_byte[0]) begin
              pending_ints_next[PEND_RX] = 1'b1;
            end
            if (data_byte[4:1] != 4'd0) begin
              pending_ints_next[PEND_LSR] = 1'b1;
            end
            if (data_byte[5]) begin
              pending_ints_next[PEND_TX] = 1'b1;
            end
          end
          ADDR_MSR: begin
            modem_status_next = data_byte;
            if (data_byte[3:0] != 4'd0) begin
              pending_ints_next[PEND_MSR] = 1'b1;
            end
          end
          ADDR_SCR: begin
            scratch_reg_next = data_byte;
          end
          default: begin
            scratch_reg_next = scratch_reg;
          end
        endcase
      end

      FUNC_RX_BYTE: begin
        push = 1'b1;
      end

      FUNC_RX_DELAY: begin
        if (ring_has_data) begin
          line_status_next[0]        = 1'b1;
          pending_ints_next[PEND_RX] = 1'b1;
        end
      end

      default: begin
        push = 1'b0;
      end
    endcase

    // Enqueue into the ring; overflow simply wraps over unread bytes.
    if (push) begin
      ram_we              = 1'b1;
      ring_write_ptr_next = ring_inc(ring_write_ptr);
      if (!line_status_next[0]) begin
        line_status_next[0]        = 1'b1;
        pending_ints_next[PEND_RX] = 1'b1;
      end
    end

    irq_next = (int_prio(int_enable_next, pending_ints_next) != IIR_NONE) &&
               (modem_control_next[3] || irq_always);
  end

  // Receive ring storage.
  u8250_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (accept && ram_we),
    .waddr (ring_write_ptr),
    .wdata (data_byte),
    .re    (accept && ram_re),
    .raddr (ring_read_ptr),
    .rdata (ram_rdata)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      irq_always <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      irq_always <= irq_always_enabled;
    end
  end

  // Register file update on each input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      int_enable     <= '0;
      line_control   <= '0;
      modem_control  <= '0;
      line_status    <= '0;
      modem_status   <= '0;
      fifo_enable    <= 1'b0;
      scratch_reg    <= '0;
      divisor_low    <= '0;
      divisor_high   <= '0;
      pending_ints   <= '0;
      ring_read_ptr  <= '0;
      ring_write_ptr <= '0;
      last_rx_data   <= '0;
      pop_pending    <= 1'b0;
    end else if (accept) begin
      int_enable     <= int_enable_next;
      line_control   <= line_control_next;
      modem_control  <= modem_control_next;
      line_status    <= line_status_next;
      modem_status   <= modem_status_next;
      fifo_enable    <= fifo_enable_next;
      scratch_reg    <= scratch_reg_next;
      divisor_low    <= divisor_low_next;
      divisor_high   <= divisor_high_next;
      pending_ints   <= pending_ints_next;
      ring_read_ptr  <= ring_read_ptr_next;
      ring_write_ptr <= ring_write_ptr_next;
      // Retire the previously popped byte before the read register is reused.
      last_rx_data   <= last_eff;
      pop_pending    <= ram_re;
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_hold      <= rd_hold_next;
      use_ring     <= use_ring_next;
      irq_level    <= irq_next;
      rts_request  <= rts_next;
      arm_rx_delay <= arm_next;
    end
  end

  // A dequeued byte comes straight from the memory read register.
  assign read_data = use_ring ? ram_rdata : rd_hold;

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for uart_8250_register_model: sends bus, receive and delay
// items, predicts every response in step with each transfer and compares it.
// Depends on u8250_pkg and the RTL of the block.
module tb;
  import u8250_pkg::*;

  // One response of the block, as the predictor computes it.
  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
    logic       rts;
    logic       arm;
  } uart_resp_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] func = '0;
  logic [2:0] bus_address = '0;
  logic [7:0] data_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] read_data;
  logic       irq_level;
  logic       rts_request;
  logic       arm_rx_delay;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       irq_always_enabled = 1'b0;

  // Predicted UART state.
  logic [3:0]         ier_q;
  logic [7:0]         lcr_q, mcr_q, lsr_q, msr_q, fcr_q, scr_q, dll_q, dlm_q, thr_q;
  logic [3:0]         iir_q, pend_q;
  logic [7:0]         ring_mem [RING_DEPTH];
  logic [RING_AW-1:0] rd_ptr, wr_ptr;
  logic [7:0]         last_rx;
  logic               irq_mode;

  uart_resp_t responses_due [$];
  uart_resp_t resp_want;

  // Shared run control.
  logic idle_on = 1'b1;
  int   hold_len = 0;
  int   hold_req_id = 0;
  int   hold_ack_id = 0;
  int   hold_left = 0;
  int   stall_left = 0;
  int   errors = 0;
  int   items_sent = 0;
  int   results_checked = 0;

  always #6 clk = ~clk;

  uart_8250_register_model i_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .func               (func),
    .bus_address        (bus_address),
    .data_byte          (data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .read_data          (read_data),
    .irq_level          (irq_level),
    .rts_request        (rts_request),
    .arm_rx_delay       (arm_rx_delay),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .irq_always_enabled (irq_always_enabled)
  );

  // Interrupt ranking: line status, receive, transmit, then modem status.
  function automatic logic [3:0] winning_ident(input logic [3:0] ier, input logic [3:0] pend);
    if (ier[2] && pend[PEND_LSR]) begin
      return IIR_LSR;
    end else if (ier[0] && pend[PEND_RX]) begin
      return IIR_RX;
    end else if (ier[1] && pend[PEND_TX]) begin
      return IIR_TX;
    end else if (ier[3] && pend[PEND_MSR]) begin
      return IIR_MSR;
    end
    return IIR_NONE;
  endfunction

  function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] p);
    return (int'(p) == RING_DEPTH - 1) ? '0 : RING_AW'(p + 1'b1);
  endfunction

  // A byte enters the ring; the pointer wraps with no overflow check.
  task automatic ring_store(input logic [7:0] b);
    ring_mem[wr_ptr] = b;
    wr_ptr = ring_next(wr_ptr);
    if (!lsr_q[0]) begin
      lsr_q[0] = 1'b1;
      pend_q[PEND_RX] = 1'b1;
      iir_q = winning_ident(ier_q, pend_q);
    end
  endtask

  // Advances the predicted state by one item and returns the response it causes.
  task automatic predict_uart_response(input func_t f, input reg_addr_t a,
                                       input logic [7:0] d, output uart_resp_t r);
    logic [7:0] m;
    r = '0;
    case (f)
      FUNC_READ: begin
        case (a)
          ADDR_DATA: begin
            if (lcr_q[7]) begin
              r.rdata = dll_q;
            end else begin
              lsr_q[0] = 1'b0;
              pend_q[PEND_RX] = 1'b0;
              iir_q = winning_ident(ier_q, pend_q);
              // An empty ring returns the byte dequeued last.
              if (rd_ptr != wr_ptr) begin
                last_rx = ring_mem[rd_ptr];
                rd_ptr = ring_next(rd_ptr);
              end
              r.rdata = last_rx;
              r.arm = (rd_ptr != wr_ptr);
            end
          end
          ADDR_IER: r.rdata = lcr_q[7] ? dlm_q : {4'b0000, ier_q};
          ADDR_IIR: begin
            r.rdata = {4'b0000, iir_q};
            if ((iir_q & 4'he) == IIR_TX) begin
              pend_q[PEND_TX] = 1'b0;
              iir_q = winning_ident(ier_q, pend_q);
            end
            if (fcr_q[0]) begin
              r.rdata[7:6] = 2'b11;
            end
          end
          ADDR_LCR: r.rdata = lcr_q;
          ADDR_MCR: r.rdata = mcr_q;
          ADDR_LSR: begin
            if (lsr_q[5]) begin
              lsr_q[6] = 1'b1;
            end
            lsr_q[5] = 1'b1;
            r.rdata = lsr_q;
            lsr_q = lsr_q & ~8'h1e;
            pend_q[PEND_LSR] = 1'b0;
            iir_q = winning_ident(ier_q, pend_q);
          end
          ADDR_MSR: begin
            r.rdata = msr_q;
            msr_q = msr_q & 8'hf0;
            pend_q[PEND_MSR] = 1'b0;
            iir_q = winning_ident(ier_q, pend_q);
          end
          default: r.rdata = scr_q;
        endcase
      end
      FUNC_WRITE: begin
        case (a)
          ADDR_DATA: begin
            if (lcr_q[7]) begin
              dll_q = d;
            end else begin
              thr_q = d;
              lsr_q[5] = 1'b1;
              pend_q[PEND_TX] = 1'b1;
              iir_q = winning_ident(ier_q, pend_q);
              if (mcr_q[4]) begin
                ring_store(d);
              end
            end
          end
          ADDR_IER: begin
            if (lcr_q[7]) begin
              dlm_q = d;
            end else begin
              ier_q = d[3:0];
              iir_q = winning_ident(ier_q, pend_q);
            end
          end
          ADDR_IIR: fcr_q = d;
          ADDR_LCR: lcr_q = d;
          ADDR_MCR: begin
            r.rts = d[1] && !mcr_q[1];
            mcr_q = d;
            // Loopback drives the modem inputs from the MCR outputs.
            if (d[4]) begin
              m = {d[3:2], d[0], d[1], 4'b0000};
              m[0] = msr_q[4] ^ m[4];
              m[1] = msr_q[5] ^ m[5];
              m[3] = msr_q[7] ^ m[7];
              m[2] = msr_q[6] && !m[6];
              msr_q = m;
            end
          end
          ADDR_LSR: begin
            lsr_q = d;
            if (d[0]) pend_q[PEND_RX] = 1'b1;
            if (|d[4:1]) pend_q[PEND_LSR] = 1'b1;
            if (d[5]) pend_q[PEND_TX] = 1'b1;
            iir_q = winning_ident(ier_q, pend_q);
          end
          ADDR_MSR: begin
            msr_q = d;
            if (|d[3:0]) pend_q[PEND_MSR] = 1'b1;
            iir_q = winning_ident(ier_q, pend_q);
          end
          default: scr_q = d;
        endcase
      end
      FUNC_RX_BYTE: ring_store(d);
      default: begin
        if (rd_ptr != wr_ptr) begin
          lsr_q[0] = 1'b1;
          pend_q[PEND_RX] = 1'b1;
          iir_q = winning_ident(ier_q, pend_q);
        end
      end
    endcase
    r.irq = (iir_q != IIR_NONE) && (mcr_q[3] || irq_mode);
  endtask

  // Offers one item, after a random gap if idle_on, and records its response on transfer.
  task automatic send_item(input func_t f, input reg_addr_t a, input logic [7:0] d);
    uart_resp_t r;
    int gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    bus_address <= a;
    data_byte <= d;
    do @(posedge clk); while (in_stall);
    predict_uart_response(f, a, d, r);
    responses_due.push_back(r);
    items_sent++;
  endtask

  task automatic drain_responses();
    in_valid <= 1'b0;
    while (responses_due.size() != 0) @(posedge clk);
  endtask

  // Writes the IRQ gate mode; only called with no response outstanding.
  task automatic set_irq_mode(input logic mode);
    cfg_valid <= 1'b1;
    irq_always_enabled <= mode;
    do @(posedge clk); while (!cfg_ready);
    irq_mode = mode;
    cfg_valid <= 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Receiver: checks each response transfer and stalls at random or for a requested stretch.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (hold_req_id != hold_ack_id) begin
        hold_left = hold_len;
        hold_ack_id = hold_req_id;
      end
      if (out_valid && !out_stall) begin
        if (responses_due.size() == 0) begin
          $display("%0t: response with no item outstanding: expected none, actual %h",
                   $time, read_data);
          errors++;
        end else begin
          resp_want = responses_due.pop_front();
          compare_field("read_data", resp_want.rdata, read_data);
          compare_field("irq_level", {7'd0, resp_want.irq}, {7'd0, irq_level});
          compare_field("rts_request", {7'd0, resp_want.rts}, {7'd0, rts_request});
          compare_field("arm_rx_delay", {7'd0, resp_want.arm}, {7'd0, arm_rx_delay});
          results_checked++;
        end
        stall_left = idle_on ? $urandom_range(0, 8) : 0;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic test_reset_state();
    send_item(FUNC_READ, ADDR_IIR, 8'h00);
    send_item(FUNC_READ, ADDR_LSR, 8'hff);
  endtask

  // Divisor latches sit behind DLAB on the data and IER offsets.
  task automatic test_divisor_latch();
    send_item(FUNC_WRITE, ADDR_LCR, 8'h80);
    send_item(FUNC_WRITE, ADDR_DATA, 8'ha5);
    send_item(FUNC_WRITE, ADDR_IER, 8'h5a);
    send_item(FUNC_READ, ADDR_DATA, 8'h00);
    send_item(FUNC_READ, ADDR_IER, 8'h00);
    send_item(FUNC_WRITE, ADDR_LCR, 8'h03);
  endtask

  // IER drops its high bits; a transmit interrupt shows in IIR and is cleared by reading it.
  task automatic test_interrupt_ident();
    send_item(FUNC_WRITE, ADDR_IER, 8'hff);
    send_item(FUNC_READ, ADDR_IER, 8'h00);
    send_item(FUNC_WRITE, ADDR_MCR, 8'h0a);
    send_item(FUNC_WRITE, ADDR_IIR, 8'h01);
    send_item(FUNC_WRITE, ADDR_DATA, 8'h00);
    send_item(FUNC_READ, ADDR_IIR, 8'h00);
  endtask

  // Receive path, delay expiry with and without queued bytes, and a read of an empty ring.
  task automatic test_rx_path();
    send_item(FUNC_RX_BYTE, ADDR_DATA, 8'hff);
    send_item(FUNC_RX_BYTE, ADDR_SCR, 8'h00);
    send_item(FUNC_READ, ADDR_DATA, 8'h00);
    send_item(FUNC_RX_DELAY, ADDR_DATA, 8'h00);
    send_item(FUNC_READ, ADDR_DATA, 8'h00);
    send_item(FUNC_READ, ADDR_DATA, 8'h00);
    send_item(FUNC_RX_DELAY, ADDR_SCR, 8'hff);
  endtask

  task automatic test_status_regs();
    send_item(FUNC_WRITE, ADDR_LSR, 8'hff);
    send_item(FUNC_READ, ADDR_LSR, 8'h00);
    send_item(FUNC_WRITE, ADDR_MSR, 8'h0f);
    send_item(FUNC_READ, ADDR_MSR, 8'h00);
  endtask

  // Loopback feeds THR writes into the ring and maps MCR onto MSR.
  task automatic test_loopback();
    send_item(FUNC_WRITE, ADDR_MCR, 8'h1f);
    send_item(FUNC_WRITE, ADDR_DATA, 8'h77);
    send_item(FUNC_READ, ADDR_DATA, 8'h00);
    send_item(FUNC_WRITE, ADDR_SCR, 8'hff);
    send_item(FUNC_READ, ADDR_SCR, 8'h00);
  endtask

  // Fills the ring past its depth while the receiver holds off, so input stalls too.
  task automatic test_ring_overflow();
    idle_on <= 1'b0;
    send_item(FUNC_WRITE, ADDR_LCR, 8'h03);
    hold_len <= 200;
    hold_req_id <= hold_req_id + 1;
    repeat (RING_DEPTH + 4) begin
      send_item(FUNC_RX_BYTE, reg_addr_t'($urandom_range(0, 7)), 8'($urandom));
    end
    repeat (6) send_item(FUNC_READ, ADDR_DATA, 8'($urandom));
    drain_responses();
    idle_on <= 1'b1;
  endtask

  // Mixed traffic: receive bursts read back in full, plus loose reads, writes and expiries.
  task automatic test_random_traffic(input int count);
    int n;
    int kind;
    int burst;
    reg_addr_t a;
    logic [7:0] d;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 49) == 0) begin
        idle_on <= ($urandom_range(0, 3) != 0);
      end
      kind = $urandom_range(0, 99);
      a = reg_addr_t'($urandom_range(0, 7));
      d = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'hff : 8'h00) : 8'($urandom);
      if (kind < 10) begin
        burst = $urandom_range(1, 6);
        repeat (burst) send_item(FUNC_RX_BYTE, a, 8'($urandom));
        repeat (burst + 1) send_item(FUNC_READ, ADDR_DATA, d);
        n += 2 * burst + 1;
      end else if (kind < 45) begin
        send_item(FUNC_READ, a, d);
        n++;
      end else if (kind < 80) begin
        // Keep DLAB mostly clear so data reads reach the ring.
        if (a == ADDR_LCR && $urandom_range(0, 3) != 0) begin
          d[7] = 1'b0;
        end
        send_item(FUNC_WRITE, a, d);
        n++;
      end else if (kind < 92) begin
        send_item(FUNC_RX_BYTE, a, d);
        n++;
      end else begin
        send_item(FUNC_RX_DELAY, a, d);
        n++;
      end
    end
  endtask

  // Main sequence.
  initial begin
    ier_q = '0;
    lcr_q = '0;
    mcr_q = '0;
    lsr_q = '0;
    msr_q = '0;
    fcr_q = '0;
    scr_q = '0;
    dll_q = '0;
    dlm_q = '0;
    thr_q = '0;
    iir_q = IIR_NONE;
    pend_q = '0;
    rd_ptr = '0;
    wr_ptr = '0;
    last_rx = '0;
    irq_mode = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_irq_mode(1'b0);
    test_reset_state();
    test_divisor_latch();
    test_interrupt_ident();
    test_rx_path();
    test_status_regs();
    test_loopback();
    drain_responses();

    set_irq_mode(1'b1);
    test_ring_overflow();
    test_random_traffic(270);
    drain_responses();
    set_irq_mode(1'b0);
    test_random_traffic(270);
    drain_responses();
    set_irq_mode(1'b1);
    test_random_traffic(270);
    drain_responses();
    repeat (4) @(posedge clk);

    $display("Sent %0d items and checked %0d responses: register access, interrupts,",
             items_sent, results_checked);
    $display("receive ring overflow, loopback and random traffic with both IRQ gate modes.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
